// File: rtl/ps2_frame_receiver_fifo_macros.svh
// ----------------------------------------------------------------------------
// PS/2 frame receiver assertion macros
// Shared property shorthands for the checker of the PS/2 frame receiver.
// ----------------------------------------------------------------------------
`ifndef PS2_FRAME_RECEIVER_FIFO_MACROS_SVH
`define PS2_FRAME_RECEIVER_FIFO_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PS2FRF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ps2 frame receiver check failed");

// The consequent holds in the cycle after the antecedent.
`define PS2FRF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ps2 frame receiver check failed");

`endif

// File: rtl/ps2frf_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver package
// Types and constants shared by the front, the back and the checker.
// ----------------------------------------------------------------------------
package ps2frf_pkg;

   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int FILL_W     = 6;

   localparam logic [3:0]  FRAME_BITS      = 4'd11;
   localparam logic [3:0]  LAST_DATA_COUNT = 4'd2;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd256;

   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_POP   = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] op;
      logic       data_bit;
   } req_type;

   typedef struct packed {
      logic              pop_valid;
      logic [7:0]        pop_byte;
      logic              frame_done;
      logic              overflow_drop;
      logic              timeout_clear;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   typedef struct packed {
      op_type kind;
      logic   data_bit;
   } cmd_type;

endpackage

// File: rtl/ps2frf_front.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver front
// Accepts items, decodes them into commands and holds them in a
// two-entry queue for the back.
// ----------------------------------------------------------------------------
module ps2frf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ps2frf_pkg::req_type req_payload,
   output logic                cmd_valid,
   output ps2frf_pkg::cmd_type cmd,
   input  logic                cmd_take
);
   import ps2frf_pkg::*;

   cmd_type    queue_ff [2];
   cmd_type    cmd_in;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid & cmd_take;
   assign cmd       = queue_ff[rd_ptr_ff];

   // The data line level only matters on a clock edge.
   always_comb begin
      cmd_in.kind     = op_type'(req_payload.op);
      cmd_in.data_bit = (op_type'(req_payload.op) == OP_EDGE) & req_payload.data_bit;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/ps2frf_back.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver back
// Executes commands: frames bits into bytes, runs the idle timeout and
// keeps the byte FIFO; drives the registered result.
// ----------------------------------------------------------------------------
module ps2frf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  ps2frf_pkg::cmd_type cmd,
   output logic                cmd_take,
   input  logic                cfg_we,
   input  logic [15:0]         cfg_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ps2frf_pkg::rsp_type rsp_payload
);
   import ps2frf_pkg::*;

   logic [7:0]       fifo_mem [FIFO_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [3:0]       countdown_ff, countdown_in;
   logic [7:0]       shift_ff, shift_in;
   logic [15:0]      idle_ff, idle_in;
   logic [15:0]      timeout_ff;
   logic [PTR_W-1:0] wr_idx_ff, wr_idx_in;
   logic [PTR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             exec;
   logic             mem_we, mem_re;
   logic [7:0]       shifted;
   logic [3:0]       count_dec;
   logic [15:0]      idle_inc;

   assign exec     = cmd_valid & (~out_valid_ff | ~rsp_stall);
   assign cmd_take = exec;

   always_comb begin
      shifted      = shift_ff;
      count_dec    = countdown_ff;
      idle_inc     = idle_ff + 16'd1;
      countdown_in = countdown_ff;
      shift_in     = shift_ff;
      idle_in      = idle_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      held_in      = held_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      out_in       = '0;

      if (countdown_ff < FRAME_BITS && countdown_ff > LAST_DATA_COUNT) begin
         shifted = {cmd.data_bit, shift_ff[7:1]};
      end
      if (countdown_ff != 4'd0) begin
         count_dec = countdown_ff - 4'd1;
      end

      if (exec) begin
         unique case (cmd.kind)
            OP_EDGE: begin
               shift_in     = shifted;
               countdown_in = count_dec;
               idle_in      = 16'd0;
               if (count_dec == 4'd0) begin
                  out_in.frame_done = 1'b1;
                  if (held_ff < CNT_W'(FIFO_DEPTH)) begin
                     mem_we    = 1'b1;
                     wr_idx_in = (wr_idx_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                 : wr_idx_ff + PTR_W'(1);
                     held_in   = held_ff + CNT_W'(1);
                  end else begin
                     out_in.overflow_drop = 1'b1;
                  end
                  shift_in     = 8'd0;
                  countdown_in = FRAME_BITS;
               end
            end
            OP_TICK: begin
               idle_in = idle_inc;
               if (idle_inc == timeout_ff) begin
                  idle_in = 16'd0;
                  if (shift_ff != 8'd0) begin
                     wr_idx_in            = '0;
                     rd_idx_in            = '0;
                     held_in              = '0;
                     countdown_in         = FRAME_BITS;
                     shift_in             = 8'd0;
                     out_in.timeout_clear = 1'b1;
                  end
               end
            end
            OP_POP: begin
               if (held_ff != '0) begin
                  mem_re           = 1'b1;
                  out_in.pop_valid = 1'b1;
                  rd_idx_in = (rd_idx_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_idx_ff + PTR_W'(1);
                  held_in   = held_ff - CNT_W'(1);
               end
            end
            OP_FLUSH: begin
               wr_idx_in    = '0;
               rd_idx_in    = '0;
               held_in      = '0;
               countdown_in = FRAME_BITS;
               shift_in     = 8'd0;
               idle_in      = 16'd0;
            end
            default: begin
               idle_in = idle_ff;
            end
         endcase
         out_in.fill_level = FILL_W'(held_in);
      end

      out_valid_in = exec | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= FRAME_BITS;
         shift_ff     <= 8'd0;
         idle_ff      <= 16'd0;
         timeout_ff   <= TIMEOUT_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         countdown_ff <= countdown_in;
         shift_ff     <= shift_in;
         idle_ff      <= idle_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
         if (cfg_we) begin
            timeout_ff <= cfg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[wr_idx_ff] <= shift_ff;
      end
      if (mem_re) begin
         rd_data_ff <= fifo_mem[rd_idx_ff];
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      rsp_payload          = out_ff;
      rsp_payload.pop_byte = out_ff.pop_valid ? rd_data_ff : 8'd0;
   end

endmodule

// File: rtl/ps2_frame_receiver_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver with byte FIFO
// An accepted item waits in the front's two-entry queue, is executed by the
// back, and gets its result from the back's output register.
// Throughput: one item per cycle when rsp_stall is low; each item is one
// pass of the back's state update with at most one FIFO memory access.
// Reset is synchronous and clears the framing, timeout and FIFO pointers;
// the FIFO memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module ps2_frame_receiver_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ps2frf_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ps2frf_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data
);
   import ps2frf_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   assign csr_ready = 1'b1;

   ps2frf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   ps2frf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take),
      .cfg_we      (csr_valid & csr_ready),
      .cfg_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/ps2frf_checker.sv
// ----------------------------------------------------------------------------
// PS/2 frame receiver checker
// Port-level properties of the receiver results, bound to the top level.
// ----------------------------------------------------------------------------
`include "ps2_frame_receiver_fifo_macros.svh"

module ps2frf_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input ps2frf_pkg::rsp_type rsp_payload
);
   import ps2frf_pkg::*;

   `PS2FRF_ASSERT_SAME(a_fill_bound, rsp_valid, rsp_payload.fill_level <= FILL_W'(FIFO_DEPTH))
   `PS2FRF_ASSERT_SAME(a_byte_only_on_pop, rsp_valid && !rsp_payload.pop_valid,
      rsp_payload.pop_byte == 8'd0)
   `PS2FRF_ASSERT_SAME(a_drop_at_frame_end, rsp_valid && rsp_payload.overflow_drop,
      rsp_payload.frame_done)
   `PS2FRF_ASSERT_SAME(a_timeout_empties, rsp_valid && rsp_payload.timeout_clear,
      rsp_payload.fill_level == '0)
   `PS2FRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload))

endmodule

bind ps2_frame_receiver_fifo ps2frf_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: tb/tb_ps2_frame_receiver_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 frame receiver with byte FIFO testbench
// Drives clock edges, time ticks, pops and flushes into the receiver with
// random bursts and gaps, stalls the result side on a changing pattern, and
// compares every result with a cycle-free model of the framing, the idle
// timeout and the FIFO. The idle timeout register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_ps2_frame_receiver_fifo;
   import ps2frf_pkg::*;

   localparam int RUN_LIMIT = 3_000_000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      req_type req;
      bit      drain;
   } bus_item_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_RUNS
   } stall_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [15:0]   csr_data = '0;

   bus_item_type  bus_items[$];
   rsp_type       awaited_rsp[$];
   int unsigned   items_queued = 0;
   int unsigned   items_taken = 0;
   int unsigned   rsps_checked = 0;
   int unsigned   failures = 0;
   int unsigned   cycle_count = 0;
   logic          req_taken = 1'b0;

   logic [3:0]    frame_count = FRAME_BITS;
   logic [7:0]    shift_reg = '0;
   logic [15:0]   idle_ticks = '0;
   logic [15:0]   timeout_setting = TIMEOUT_RESET;
   logic [7:0]    byte_store [FIFO_DEPTH];
   int unsigned   wr_ptr = 0;
   int unsigned   rd_ptr = 0;
   int unsigned   held = 0;

   ps2_frame_receiver_fifo u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void clear_receiver();
      frame_count = FRAME_BITS;
      shift_reg = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      held = 0;
   endfunction

   function automatic rsp_type decode_item(input req_type item);
      rsp_type res;
      res = '0;
      case (op_type'(item.op))
         OP_EDGE: begin
            if (frame_count < FRAME_BITS && frame_count > LAST_DATA_COUNT) begin
               shift_reg = {item.data_bit, shift_reg[7:1]};
            end
            if (frame_count > 0) begin
               frame_count = frame_count - 4'd1;
            end
            if (frame_count == 0) begin
               res.frame_done = 1'b1;
               if (held < FIFO_DEPTH) begin
                  byte_store[wr_ptr] = shift_reg;
                  wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                  held++;
               end else begin
                  res.overflow_drop = 1'b1;
               end
               shift_reg = '0;
               frame_count = FRAME_BITS;
            end
            idle_ticks = '0;
         end
         OP_TICK: begin
            idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks == timeout_setting) begin
               idle_ticks = '0;
               if (shift_reg != 0) begin
                  clear_receiver();
                  res.timeout_clear = 1'b1;
               end
            end
         end
         OP_POP: begin
            if (held > 0) begin
               res.pop_valid = 1'b1;
               res.pop_byte = byte_store[rd_ptr];
               rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
               held--;
            end
         end
         default: begin
            clear_receiver();
            idle_ticks = '0;
         end
      endcase
      res.fill_level = FILL_W'(held);
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(decode_item(req_payload));
            items_taken <= items_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("result arrived with nothing expected");
               failures++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("pop_valid", want.pop_valid, rsp_payload.pop_valid);
               check_field("pop_byte", want.pop_byte, rsp_payload.pop_byte);
               check_field("frame_done", want.frame_done, rsp_payload.frame_done);
               check_field("overflow_drop", want.overflow_drop, rsp_payload.overflow_drop);
               check_field("timeout_clear", want.timeout_clear, rsp_payload.timeout_clear);
               check_field("fill_level", want.fill_level, rsp_payload.fill_level);
            end
            rsps_checked <= rsps_checked + 1;
         end
      end
   end

   always @(negedge clock) begin
      static int unsigned burst_left = 1;
      static int unsigned gap_left = 0;
      bus_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_items.size() > 0 &&
                      !(bus_items[0].drain && items_taken != rsps_checked)) begin
            item = bus_items.pop_front();
            req_valid <= 1'b1;
            req_payload <= item.req;
            if (burst_left > 0) begin
               burst_left--;
            end
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      static stall_mode_type stall_mode = STALL_NONE;
      static int unsigned mode_left = 0;
      static int unsigned run_left = 0;
      static bit stall_on = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               if (run_left == 0) begin
                  stall_on = !stall_on;
                  run_left = $urandom_range(1, 6);
               end
               run_left--;
               rsp_stall <= stall_on;
            end
         endcase
      end
   end

   task automatic push_item(input op_type kind, input logic data_bit, input bit drain = 1'b0);
      bus_item_type item;
      item.req.op = kind;
      item.req.data_bit = data_bit;
      item.drain = drain;
      bus_items.push_back(item);
      items_queued++;
   endtask

   task automatic push_frame(input logic [7:0] data);
      push_item(OP_EDGE, 1'b0);
      for (int i = 0; i < 8; i++) begin
         push_item(OP_EDGE, data[i]);
      end
      push_item(OP_EDGE, ~^data);
      push_item(OP_EDGE, 1'b1);
   endtask

   task automatic push_ticks(input int unsigned count);
      repeat (count) push_item(OP_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle();
      while (rsps_checked != items_queued) @(negedge clock);
   endtask

   task automatic set_idle_timeout(input logic [15:0] ticks);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= ticks;
      do @(posedge clock); while (!csr_ready);
      timeout_setting = ticks;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int unsigned count, input bit few_pops);
      int unsigned target;
      int unsigned pick;
      int unsigned tick_span;
      target = items_queued + count;
      tick_span = (timeout_setting == 0 || timeout_setting > 38) ? 40 : timeout_setting + 2;
      while (items_queued < target) begin
         pick = $urandom_range(0, 99);
         if (few_pops && pick >= 40 && pick < 55 && $urandom_range(0, 3) != 0) begin
            pick = 0;
         end
         if (pick < 40) begin
            push_frame(8'($urandom_range(0, 255)));
         end else if (pick < 55) begin
            push_item(OP_POP, 1'($urandom_range(0, 1)), $urandom_range(0, 24) == 0);
         end else if (pick < 63) begin
            push_ticks($urandom_range(1, tick_span));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 10)) push_item(OP_EDGE, 1'($urandom_range(0, 1)));
            push_ticks($urandom_range(1, tick_span));
         end else if (pick < 78) begin
            push_item(OP_FLUSH, 1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            push_item(OP_EDGE, 1'($urandom_range(0, 1)));
         end else begin
            push_item(op_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int unsigned base;
      int unsigned timeout_choices[] = '{1, 2, 3, 4, 6, 9, 15};
      int unsigned pick;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      push_item(OP_POP, 1'b1);
      push_item(OP_FLUSH, 1'b1);
      push_item(OP_TICK, 1'b0);
      push_frame(8'h00);
      push_frame(8'hFF);
      push_item(OP_POP, 1'b0);
      push_item(OP_POP, 1'b1);
      push_item(OP_POP, 1'b0);
      push_item(OP_EDGE, 1'b0);
      push_item(OP_EDGE, 1'b1);
      push_item(OP_FLUSH, 1'b0);
      push_item(OP_POP, 1'b1, 1'b1);
      wait_idle();

      set_idle_timeout(16'hFFFF);
      push_frame(8'($urandom_range(0, 255)));
      push_item(OP_EDGE, 1'b0);
      push_item(OP_EDGE, 1'b1);
      push_ticks(100);
      push_item(OP_POP, 1'b0);
      wait_idle();

      set_idle_timeout(16'd1000);
      push_item(OP_EDGE, 1'b0);
      push_item(OP_EDGE, 1'b1);
      push_ticks(60);
      wait_idle();

      set_idle_timeout(16'd0);
      push_ticks(100);
      push_item(OP_POP, 1'b1);
      wait_idle();

      set_idle_timeout(16'd3);
      base = items_queued;
      repeat (FIFO_DEPTH + 2) push_frame(8'($urandom_range(0, 255)));
      repeat (2) push_item(OP_POP, 1'($urandom_range(0, 1)));
      repeat (3) push_frame(8'($urandom_range(0, 255)));
      repeat (FIFO_DEPTH + 2) push_item(OP_POP, 1'($urandom_range(0, 1)));

      while (items_queued - base < RANDOM_ITEMS) begin
         wait_idle();
         pick = $urandom_range(0, 9);
         if (pick < timeout_choices.size()) begin
            set_idle_timeout(16'(timeout_choices[pick]));
         end else if (pick == 9) begin
            set_idle_timeout(16'hFFFF);
         end else begin
            set_idle_timeout(16'($urandom_range(1, 40)));
         end
         random_phase($urandom_range(60, 160), $urandom_range(0, 2) == 0);
      end
      wait_idle();
      repeat (10) @(negedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/ps2frf_pkg.sv
rtl/ps2frf_front.sv
rtl/ps2frf_back.sv
rtl/ps2_frame_receiver_fifo.sv
rtl/ps2frf_checker.sv
tb/tb_ps2_frame_receiver_fifo.sv
